// ===== src/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== src/prqs_pkg.sv =====
// -----------------------------------------------------------------------------
// prqs_pkg
// Shared constants and types for the priority ready-queue scheduler.
// -----------------------------------------------------------------------------
package prqs_pkg;
  localparam int PoolNodes = 256;
  localparam int Levels = 32;
  localparam int PiRecords = 8;
  localparam int NodeW = $clog2(PoolNodes);
  localparam int LvlW = $clog2(Levels);
  localparam int PiW = $clog2(PiRecords);

  typedef enum logic [2:0] {
    OP_ENQ = 3'd0, OP_SEL = 3'd1, OP_SET = 3'd2, OP_REM = 3'd3,
    OP_INH = 3'd4, OP_UNINH = 3'd5, OP_TICK = 3'd6, OP_BAD = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOTFOUND = 3'd1, ST_FULL = 3'd2, ST_DEPTH = 3'd3,
    ST_REFUSED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_RUNNING = 3'd0, CFG_AGING_EN = 3'd1, CFG_PERIOD = 3'd2,
    CFG_THRESH = 3'd3, CFG_BOOST = 3'd4, CFG_INH_EN = 3'd5, CFG_DEPTH = 3'd6
  } cfg_idx_t;
endpackage

// ===== src/priority_ready_queue_scheduler.sv =====
// -----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Ready-queue scheduler with one FIFO per priority level over a node pool.
// -----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready with op, task_id, priority_req
// and resource_id; each request yields exactly one word on out_valid/
// out_ready carrying status, out_task_id and out_priority.
// Per-node state (task, priority, enqueue time, links) sits in one
// synchronous memory with a registered read; a sequencer walks it.
// Enqueue takes the free node straight from the used bitmap; aging, if due,
// follows a select. Set, remove, inherit and uninherit walk the level lists
// node by node and level by level, then move the node. An aging pass walks
// the queued nodes above level 0 and moves each boosted node.
// One request is handled at a time.
// Reset clears the used flags, level counts, time and inheritance records
// directly; no clearing pass is needed. The result is held in an
// output register; a stalled receiver holds the block, and a new request
// is taken once the held word has been taken.
// Configuration is to be written on cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"
module priority_ready_queue_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [7:0]  task_id,
  input  logic [4:0]  priority_req,
  input  logic [7:0]  resource_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  out_task_id,
  output logic [4:0]  out_priority,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import prqs_pkg::*;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [LvlW-1:0] lvl_t;
  typedef struct packed {
    logic [7:0]  tsk;
    lvl_t        prio;
    logic [31:0] etime;
    node_t       nxt;
    node_t       prv;
  } node_rec_t;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001, S_DISP  = 15'h0002, S_FREE  = 15'h0004,
    S_FIND   = 15'h0008, S_FWAIT = 15'h0010, S_UNL   = 15'h0020,
    S_UNL2   = 15'h0040, S_PUSH  = 15'h0080, S_PUSH2 = 15'h0100,
    S_AGEL   = 15'h0200, S_AGEW  = 15'h0400, S_AGEC  = 15'h0800,
    S_DONE   = 15'h1000, S_OUT   = 15'h2000, S_RDW   = 15'h4000
  } state_t;

  // unlink/push purposes
  typedef enum logic [2:0] {
    P_SEL = 3'd0, P_SET = 3'd1, P_REM = 3'd2, P_INH = 3'd3, P_UNINH = 3'd4,
    P_AGE = 3'd5, P_ENQ = 3'd6
  } purp_t;

  // configuration
  logic        running, aging_enable, inherit_enable;
  logic [15:0] aging_period, aging_threshold;
  logic [4:0]  boost_lvls;
  logic [3:0]  max_inherit_depth;

  // level state (32 entries, indexed by a signal but small -> registers with
  // fixed update per op; heads/tails registered)
  node_t       level_head [Levels];
  node_t       level_tail [Levels];
  logic [NodeW:0] level_count [Levels];
  logic [Levels-1:0] level_nonempty;
  logic [PoolNodes-1:0] node_used;
  logic [31:0] time_now, aged_at;
  logic [7:0]  pi_task [PiRecords];
  logic [7:0]  pi_resource [PiRecords];
  lvl_t        pi_original [PiRecords];
  logic [PiRecords-1:0] pi_valid;
  logic [PiW:0] pi_active;

  // node memory
  node_rec_t mem [PoolNodes];
  node_rec_t rd;
  node_t     raddr;
  logic      we;
  node_t     waddr;
  node_rec_t wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  state_t state;
  purp_t  purp;
  logic [2:0]  r_op;
  logic [7:0]  r_task, r_res;
  lvl_t        r_prio;
  logic [2:0]  st;
  logic [7:0]  ot;
  lvl_t        opr;
  node_t       cur_n;     // node being moved
  node_rec_t   cur_rec;
  lvl_t        cur_lvl, new_lvl;
  lvl_t        walk_lvl;
  logic [NodeW:0] walk_k, walk_cnt;
  node_t       walk_n, age_next;
  logic [1:0]  ustep;

  // combinational search helpers over flops
  node_t       free_n;
  logic        free_ok;
  lvl_t        sel_lvl;
  logic        sel_ok;
  logic [PiW-1:0] pi_free_i, pi_match_i;
  logic        pi_free_ok, pi_match_ok;

  always_comb begin
    free_n = '0; free_ok = 1'b0;
    for (int i = PoolNodes-1; i >= 0; i--)
      if (!node_used[i]) begin free_n = node_t'(i); free_ok = 1'b1; end
    sel_lvl = '0; sel_ok = 1'b0;
    for (int i = Levels-1; i >= 0; i--)
      if (level_nonempty[i]) begin sel_lvl = lvl_t'(i); sel_ok = 1'b1; end
    pi_free_i = '0; pi_free_ok = 1'b0; pi_match_i = '0; pi_match_ok = 1'b0;
    for (int i = PiRecords-1; i >= 0; i--) begin
      if (!pi_valid[i]) begin pi_free_i = PiW'(i); pi_free_ok = 1'b1; end
      if (pi_valid[i] && pi_task[i] == r_task && pi_resource[i] == r_res) begin
        pi_match_i = PiW'(i); pi_match_ok = 1'b1;
      end
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign status = st;
  assign out_task_id = ot;
  assign out_priority = opr;

  logic [31:0] wait_t;
  logic [4:0]  boosted;
  assign wait_t = time_now - rd.etime;
  assign boosted = ({1'b0, rd.prio} >= {1'b0, boost_lvls}) ?
                   5'(rd.prio) - boost_lvls : 5'd0;

  logic age_due;
  assign age_due = aging_enable && ((time_now - aged_at) >= {16'd0, aging_period});

  // memory port control is combinational from state
  always_comb begin
    raddr = walk_n;
    we = 1'b0; waddr = cur_n; wdata = cur_rec;
    case (state)
      S_UNL: begin
        // ustep 0: read prev, 1: write prev.next, read next; 2: write next.prev
        raddr = (ustep == 2'd0) ? cur_rec.prv : cur_rec.nxt;
        if (ustep == 2'd1) begin
          we = (level_head[cur_lvl] != cur_n); waddr = cur_rec.prv;
          wdata = rd; wdata.nxt = cur_rec.nxt;
        end else if (ustep == 2'd2) begin
          we = (level_tail[cur_lvl] != cur_n); waddr = cur_rec.nxt;
          wdata = rd; wdata.prv = cur_rec.prv;
        end
      end
      S_PUSH: raddr = level_tail[new_lvl];
      S_PUSH2: begin
        we = 1'b1; waddr = level_tail[new_lvl]; wdata = rd; wdata.nxt = cur_n;
      end
      S_UNL2: begin
        we = 1'b1; waddr = cur_n; wdata = cur_rec;
        wdata.prio = new_lvl;
        if (level_count[new_lvl] != '0) wdata.prv = level_tail[new_lvl];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      running <= 1'b0; aging_enable <= 1'b1; aging_period <= 16'd100;
      aging_threshold <= 16'd1000; boost_lvls <= 5'd1; inherit_enable <= 1'b1;
      max_inherit_depth <= 4'd8;
      node_used <= '0; level_nonempty <= '0;
      for (int i = 0; i < Levels; i++) level_count[i] <= '0;
      time_now <= '0; aged_at <= '0; pi_valid <= '0; pi_active <= '0;
      ustep <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RUNNING: begin
            if (!running && cfg_data[0]) aged_at <= time_now;
            running <= cfg_data[0];
          end
          CFG_AGING_EN: aging_enable <= cfg_data[0];
          CFG_PERIOD:   aging_period <= cfg_data;
          CFG_THRESH:   aging_threshold <= cfg_data;
          CFG_BOOST:    boost_lvls <= cfg_data[4:0];
          CFG_INH_EN:   inherit_enable <= cfg_data[0];
          CFG_DEPTH:    max_inherit_depth <= cfg_data[3:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          r_op <= op; r_task <= task_id; r_prio <= priority_req; r_res <= resource_id;
          st <= ST_REFUSED; ot <= '0; opr <= '0;
          state <= S_DISP;
        end
        S_DISP: begin
          case (op_t'(r_op))
            OP_ENQ: if (!free_ok) begin
                st <= ST_FULL; state <= S_OUT;
              end else begin
                node_used[free_n] <= 1'b1;
                cur_n <= free_n; new_lvl <= r_prio;
                cur_rec <= '{tsk: r_task, prio: r_prio, etime: time_now,
                             nxt: '0, prv: '0};
                purp <= P_ENQ; st <= ST_OK; state <= S_UNL2;
              end
            OP_SEL: if (running) begin
                if (sel_ok) begin
                  cur_n <= level_head[sel_lvl]; walk_n <= level_head[sel_lvl];
                  cur_lvl <= sel_lvl; purp <= P_SEL; state <= S_RDW;
                end else begin
                  st <= ST_NOTFOUND; state <= S_DONE;
                end
              end else state <= S_OUT;
            OP_SET: begin purp <= P_SET; state <= S_FIND; walk_lvl <= '0;
                          walk_k <= '0; end
            OP_REM: begin purp <= P_REM; state <= S_FIND; walk_lvl <= '0;
                          walk_k <= '0; end
            OP_INH: if (inherit_enable) begin
                if ({1'b0, pi_active} >= 5'(max_inherit_depth)) begin
                  st <= ST_DEPTH; state <= S_OUT;
                end else begin purp <= P_INH; state <= S_FIND; walk_lvl <= '0;
                           walk_k <= '0; end
              end else state <= S_OUT;
            OP_UNINH: begin
                if (pi_match_ok) begin
                  pi_valid[pi_match_i] <= 1'b0;
                  if (pi_active != '0) pi_active <= pi_active - 1'b1;
                  st <= ST_OK; purp <= P_UNINH; new_lvl <= pi_original[pi_match_i];
                  state <= S_FIND; walk_lvl <= '0; walk_k <= '0;
                end else begin
                  st <= ST_NOTFOUND; state <= S_OUT;
                end
              end
            OP_TICK: begin time_now <= time_now + 1'b1; st <= ST_OK; state <= S_OUT; end
            default: state <= S_OUT;
          endcase
        end
        S_RDW: state <= S_FWAIT;  // memory read issued at walk_n
        S_FIND: begin
          // read the next node of this level, else step to the next level, or conclude
          if (walk_k < level_count[walk_lvl]) begin
            walk_n <= (walk_k == '0) ? level_head[walk_lvl] : walk_n;
            state <= S_RDW;
          end else if (walk_lvl == lvl_t'(Levels-1)) begin
            // not found
            case (purp)
              P_INH: begin
                if (r_prio < lvl_t'(Levels-1)) begin
                  if (!pi_free_ok) st <= ST_FULL;
                  else begin
                    pi_valid[pi_free_i] <= 1'b1; pi_task[pi_free_i] <= r_task;
                    pi_resource[pi_free_i] <= r_res;
                    pi_original[pi_free_i] <= lvl_t'(Levels-1);
                    pi_active <= pi_active + 1'b1; st <= ST_OK;
                  end
                end else st <= ST_OK;
              end
              P_UNINH: ;
              default: st <= ST_NOTFOUND;
            endcase
            state <= S_OUT;
          end else begin
            walk_lvl <= walk_lvl + 1'b1; walk_k <= '0;
          end
        end
        S_FWAIT: begin
          if (purp == P_SEL) begin
            cur_rec <= rd; node_used[cur_n] <= 1'b0;
            ot <= rd.tsk; opr <= cur_lvl; st <= ST_OK;
            ustep <= '0; state <= S_UNL;
          end else if (rd.tsk == r_task) begin
            cur_n <= walk_n; cur_rec <= rd; cur_lvl <= walk_lvl; ustep <= '0;
            case (purp)
              P_SET: begin new_lvl <= r_prio; st <= ST_OK; state <= S_UNL; end
              P_REM: begin
                node_used[walk_n] <= 1'b0; st <= ST_OK; state <= S_UNL;
              end
              P_INH: begin
                if (r_prio < rd.prio) begin
                  if (!pi_free_ok) begin st <= ST_FULL; state <= S_OUT; end
                  else begin
                    pi_valid[pi_free_i] <= 1'b1; pi_task[pi_free_i] <= r_task;
                    pi_resource[pi_free_i] <= r_res;
                    pi_original[pi_free_i] <= rd.prio;
                    pi_active <= pi_active + 1'b1; new_lvl <= r_prio;
                    st <= ST_OK; state <= S_UNL;
                  end
                end else begin st <= ST_OK; state <= S_OUT; end
              end
              P_UNINH: state <= S_UNL;
              default: state <= S_OUT;
            endcase
          end else begin
            walk_n <= rd.nxt; walk_k <= walk_k + 1'b1; state <= S_FIND;
          end
        end
        S_UNL: begin
          if (ustep == 2'd2) begin
            ustep <= '0;
            if (level_head[cur_lvl] == cur_n && level_tail[cur_lvl] != cur_n)
              level_head[cur_lvl] <= cur_rec.nxt;
            if (level_tail[cur_lvl] == cur_n && level_head[cur_lvl] != cur_n)
              level_tail[cur_lvl] <= cur_rec.prv;
            level_count[cur_lvl] <= level_count[cur_lvl] - 1'b1;
            if (level_count[cur_lvl] == (NodeW+1)'(1)) level_nonempty[cur_lvl] <= 1'b0;
            if (purp == P_SEL) state <= S_DONE;
            else if (purp == P_REM) state <= S_OUT;
            else state <= S_UNL2;
          end else ustep <= ustep + 1'b1;
        end
        S_UNL2: begin
          // write node with new level and prev; then link tail
          if (level_count[new_lvl] == '0) begin
            level_head[new_lvl] <= cur_n;
            level_tail[new_lvl] <= cur_n;
            level_count[new_lvl] <= level_count[new_lvl] + 1'b1;
            level_nonempty[new_lvl] <= 1'b1;
            state <= (purp == P_AGE) ? S_AGEC : S_OUT;
          end else state <= S_PUSH;
        end
        S_PUSH: state <= S_PUSH2;
        S_PUSH2: begin
          level_tail[new_lvl] <= cur_n;
          level_count[new_lvl] <= level_count[new_lvl] + 1'b1;
          level_nonempty[new_lvl] <= 1'b1;
          state <= (purp == P_AGE) ? S_AGEC : S_OUT;
        end
        S_DONE: begin
          // aging check after select
          if (age_due) begin
            aged_at <= time_now;
            purp <= P_AGE; walk_lvl <= lvl_t'(1); walk_k <= '0;
            walk_cnt <= level_count[1]; walk_n <= level_head[1];
            state <= S_AGEL;
          end else state <= S_OUT;
        end
        S_AGEL: begin
          if (walk_k < walk_cnt) state <= S_AGEW;
          else if (walk_lvl == lvl_t'(Levels-1)) state <= S_OUT;
          else begin
            walk_lvl <= walk_lvl + 1'b1; walk_k <= '0;
            walk_cnt <= level_count[walk_lvl + 1'b1];
            walk_n <= level_head[walk_lvl + 1'b1];
          end
        end
        S_AGEW: begin
          // read issued at walk_n this cycle; evaluate next cycle
          state <= S_AGEC; ustep <= 2'd3;
        end
        S_AGEC: begin
          if (ustep == 2'd3) begin
            walk_k <= walk_k + 1'b1; age_next <= rd.nxt; walk_n <= rd.nxt;
            if (wait_t > {16'd0, aging_threshold} && boosted < 5'(rd.prio)) begin
              cur_n <= walk_n; cur_rec <= rd; cur_lvl <= walk_lvl;
              new_lvl <= lvl_t'(boosted); ustep <= '0; state <= S_UNL;
            end else state <= S_AGEL;
          end else begin
            walk_n <= age_next; state <= S_AGEL;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPLIES(a_one_busy, clk, rst, out_valid, !in_ready)
  `ASSERT_IMPLIES(a_pi_bound, clk, rst, 1'b1, pi_active <= (PiW+1)'(PiRecords))
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
endmodule

// ===== sim/prqs_checker.sv =====
// -----------------------------------------------------------------------------
// prqs_checker
// Watches the request, result and configuration ports of the ready-queue
// scheduler. It keeps its own copy of the node pool, level lists, time and
// inheritance records, and queues one predicted word for every request taken.
// Each result word taken is compared field by field with the oldest one.
// -----------------------------------------------------------------------------
module prqs_checker
  import prqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  op,
  input  logic [7:0]  task_id,
  input  logic [4:0]  priority_req,
  input  logic [7:0]  resource_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [7:0]  out_task_id,
  input  logic [4:0]  out_priority,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0] st;
    logic [7:0] tid;
    logic [4:0] prio;
  } sched_word_t;

  sched_word_t expected_words[$];

  // configuration copy
  logic        running, aging_en, inh_en;
  logic [15:0] period, thresh;
  logic [4:0]  boost;
  logic [3:0]  depth_max;

  // scheduler copy
  logic [7:0]  nd_task [PoolNodes];
  int          nd_prio [PoolNodes];
  logic [31:0] nd_time [PoolNodes];
  int          nd_next [PoolNodes];
  int          nd_prev [PoolNodes];
  bit          nd_used [PoolNodes];
  int          lv_head [Levels];
  int          lv_tail [Levels];
  int          lv_cnt  [Levels];
  logic [31:0] time_now, last_aging;
  logic [7:0]  pi_task [PiRecords];
  logic [7:0]  pi_res  [PiRecords];
  int          pi_orig [PiRecords];
  bit          pi_used [PiRecords];
  int          pi_active;

  function automatic void append_node(int lvl, int n);
    if (lv_cnt[lvl] == 0) begin
      lv_head[lvl] = n;
    end else begin
      nd_next[lv_tail[lvl]] = n;
      nd_prev[n] = lv_tail[lvl];
    end
    lv_tail[lvl] = n;
    lv_cnt[lvl]++;
  endfunction

  function automatic void unlink_node(int lvl, int n);
    bit at_head, at_tail;
    at_head = (lv_head[lvl] == n);
    at_tail = (lv_tail[lvl] == n);
    if (!at_head) nd_next[nd_prev[n]] = nd_next[n];
    else if (!at_tail) lv_head[lvl] = nd_next[n];
    if (!at_tail) nd_prev[nd_next[n]] = nd_prev[n];
    else if (!at_head) lv_tail[lvl] = nd_prev[n];
    lv_cnt[lvl]--;
  endfunction

  // first match, levels ascending, each from head to tail
  function automatic int locate_task(logic [7:0] t, output int lvl);
    int n;
    lvl = 0;
    for (int l = 0; l < Levels; l++) begin
      n = lv_head[l];
      for (int k = 0; k < lv_cnt[l]; k++) begin
        if (nd_task[n] == t) begin
          lvl = l;
          return n;
        end
        n = nd_next[n];
      end
    end
    return PoolNodes;
  endfunction

  function automatic logic [2:0] move_task(logic [7:0] t, int np);
    int lvl, n;
    n = locate_task(t, lvl);
    if (n >= PoolNodes) return ST_NOTFOUND;
    unlink_node(lvl, n);
    nd_prio[n] = np;
    append_node(np, n);
    return ST_OK;
  endfunction

  // visit each node once: the count is latched before the walk of a level
  function automatic void age_nodes();
    int cnt, n, nx, np;
    for (int l = 1; l < Levels; l++) begin
      cnt = lv_cnt[l];
      n = lv_head[l];
      for (int k = 0; k < cnt; k++) begin
        nx = nd_next[n];
        if (time_now - nd_time[n] > {16'd0, thresh}) begin
          np = (nd_prio[n] >= boost) ? nd_prio[n] - boost : 0;
          if (np < nd_prio[n]) begin
            unlink_node(l, n);
            nd_prio[n] = np;
            append_node(np, n);
          end
        end
        n = nx;
      end
    end
  endfunction

  function automatic sched_word_t schedule_request(logic [2:0] code, logic [7:0] t,
                                                   logic [4:0] p, logic [7:0] r);
    sched_word_t w;
    int n, lvl, cur, i;
    logic [2:0] dummy;
    w = '{st: ST_REFUSED, tid: 8'd0, prio: 5'd0};
    case (op_t'(code))
      OP_ENQ: begin
        for (n = 0; n < PoolNodes && nd_used[n]; n++) begin end
        if (n >= PoolNodes) begin
          w.st = ST_FULL;
        end else begin
          nd_used[n] = 1'b1;
          nd_task[n] = t;
          nd_prio[n] = p;
          nd_time[n] = time_now;
          append_node(p, n);
          w.st = ST_OK;
        end
      end
      OP_SEL: begin
        if (running) begin
          w.st = ST_NOTFOUND;
          for (lvl = 0; lvl < Levels; lvl++) begin
            if (lv_cnt[lvl] != 0) begin
              n = lv_head[lvl];
              unlink_node(lvl, n);
              nd_used[n] = 1'b0;
              w.tid = nd_task[n];
              w.prio = lvl[4:0];
              w.st = ST_OK;
              break;
            end
          end
          if (aging_en && (time_now - last_aging) >= {16'd0, period}) begin
            age_nodes();
            last_aging = time_now;
          end
        end
      end
      OP_SET: w.st = move_task(t, p);
      OP_REM: begin
        n = locate_task(t, lvl);
        if (n >= PoolNodes) begin
          w.st = ST_NOTFOUND;
        end else begin
          unlink_node(lvl, n);
          nd_used[n] = 1'b0;
          w.st = ST_OK;
        end
      end
      OP_INH: begin
        if (inh_en) begin
          if (pi_active >= depth_max) begin
            w.st = ST_DEPTH;
          end else begin
            n = locate_task(t, lvl);
            cur = (n < PoolNodes) ? nd_prio[n] : Levels - 1;
            w.st = ST_OK;
            if (p < cur) begin
              for (i = 0; i < PiRecords && pi_used[i]; i++) begin end
              if (i >= PiRecords) begin
                w.st = ST_FULL;
              end else begin
                pi_used[i] = 1'b1;
                pi_task[i] = t;
                pi_res[i] = r;
                pi_orig[i] = cur;
                dummy = move_task(t, p);
                pi_active++;
              end
            end
          end
        end
      end
      OP_UNINH: begin
        w.st = ST_NOTFOUND;
        for (i = 0; i < PiRecords; i++) begin
          if (pi_used[i] && pi_task[i] == t && pi_res[i] == r) begin
            dummy = move_task(t, pi_orig[i]);
            pi_used[i] = 1'b0;
            if (pi_active > 0) pi_active--;
            w.st = ST_OK;
            break;
          end
        end
      end
      OP_TICK: begin
        time_now++;
        w.st = ST_OK;
      end
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    sched_word_t want;
    if (rst) begin
      running = 1'b0; aging_en = 1'b1; period = 16'd100; thresh = 16'd1000;
      boost = 5'd1; inh_en = 1'b1; depth_max = 4'd8;
      for (int i = 0; i < PoolNodes; i++) nd_used[i] = 1'b0;
      for (int i = 0; i < Levels; i++) lv_cnt[i] = 0;
      for (int i = 0; i < PiRecords; i++) pi_used[i] = 1'b0;
      time_now = 32'd0; last_aging = 32'd0; pi_active = 0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RUNNING: begin
            if (!running && cfg_data[0]) last_aging = time_now;
            running = cfg_data[0];
          end
          CFG_AGING_EN: aging_en = cfg_data[0];
          CFG_PERIOD:   period = cfg_data;
          CFG_THRESH:   thresh = cfg_data;
          CFG_BOOST:    boost = cfg_data[4:0];
          CFG_INH_EN:   inh_en = cfg_data[0];
          CFG_DEPTH:    depth_max = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: status %0d task %0d prio %0d",
                 status, out_task_id, out_priority);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count++;
          end
          if (out_task_id !== want.tid) begin
            $error("out_task_id: expected %0d, got %0d", want.tid, out_task_id);
            fail_count++;
          end
          if (out_priority !== want.prio) begin
            $error("out_priority: expected %0d, got %0d", want.prio, out_priority);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(schedule_request(op, task_id, priority_req, resource_id));
    end
    pending = expected_words.size();
  end

endmodule

// ===== sim/testbench.sv =====
// -----------------------------------------------------------------------------
// testbench
// Drives requests and configuration into the ready-queue scheduler: a directed
// opening, then random phases under several register settings, including a
// pool-filling phase, aggressive aging and inheritance limits. A side checker
// predicts and compares every result word; this module gives the verdict.
// -----------------------------------------------------------------------------
module testbench;
  import prqs_pkg::*;

  localparam int IdleLimit = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = OP_TICK;
  logic [7:0]  task_id = 8'd0;
  logic [4:0]  priority_req = 5'd0;
  logic [7:0]  resource_id = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  out_task_id;
  logic [4:0]  out_priority;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_RUNNING;
  logic [15:0] cfg_data = 16'd0;
  int          fail_count;
  int          pending;
  int          idle_cycles;

  always #5 clk = ~clk;

  priority_ready_queue_scheduler dut (.*);
  prqs_checker checker_i (.*);

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int gap;
    int words_taken;
    words_taken = 0;
    @(negedge clk);
    wait (!rst);
    forever begin
      gap = (words_taken == 180) ? 400 : $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0 && words_taken != 180) gap = 0;
      if (gap > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      words_taken++;
    end
  end

  task automatic send_word(op_t code, logic [7:0] t, logic [4:0] p, logic [7:0] r,
                           bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op <= code;
    task_id <= t;
    priority_req <= p;
    resource_id <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // hold until every word is back, then let the block settle
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // tasks and resources mostly from small sets so lookups and records hit
  task automatic random_phase(int count, int enq_pct, bit burst);
    int roll;
    op_t code;
    logic [7:0] t, r;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) code = OP_ENQ;
      else begin
        roll = $urandom_range(0, 99);
        if (roll < 28) code = OP_SEL;
        else if (roll < 48) code = OP_TICK;
        else if (roll < 62) code = OP_SET;
        else if (roll < 74) code = OP_REM;
        else if (roll < 86) code = OP_INH;
        else if (roll < 98) code = OP_UNINH;
        else code = OP_BAD;
      end
      t = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11) * 21);
      r = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3) * 85);
      send_word(code, t, 5'($urandom), r, burst && i < count / 3);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // not running yet: select and unknown op are refused
    send_word(OP_SEL, 8'd0, 5'd0, 8'd0);
    send_word(OP_BAD, 8'hff, 5'd31, 8'hff);
    send_word(OP_ENQ, 8'd0, 5'd0, 8'd0);
    send_word(OP_ENQ, 8'hff, 5'd31, 8'd0);
    send_word(OP_ENQ, 8'hff, 5'd31, 8'd0);  // duplicate task
    send_word(OP_SET, 8'hff, 5'd5, 8'd0);
    send_word(OP_REM, 8'hff, 5'd0, 8'd0);
    send_word(OP_REM, 8'd99, 5'd0, 8'd0);
    send_word(OP_SET, 8'd99, 5'd3, 8'd0);
    send_word(OP_INH, 8'd0, 5'd4, 8'haa);   // no gain, nothing recorded
    send_word(OP_INH, 8'hff, 5'd2, 8'haa);
    send_word(OP_INH, 8'd77, 5'd3, 8'h55);  // task not queued, record kept
    send_word(OP_UNINH, 8'hff, 5'd0, 8'haa);
    send_word(OP_UNINH, 8'd77, 5'd0, 8'h55);
    send_word(OP_UNINH, 8'd1, 5'd0, 8'h01);
    send_word(OP_TICK, 8'd0, 5'd0, 8'd0);
    drain();
    write_reg(CFG_RUNNING, 16'd1);
    send_word(OP_SEL, 8'd0, 5'd0, 8'd0);
    send_word(OP_SEL, 8'd0, 5'd0, 8'd0);
    send_word(OP_SEL, 8'd0, 5'd0, 8'd0);    // all levels empty
    drain();

    // default settings, then fill the pool to overflow
    random_phase(110, 30, 1'b1);
    drain();
    write_reg(CFG_AGING_EN, 16'd0);
    random_phase(290, 92, 1'b0);
    drain();

    // aggressive aging: every select ages, any wait boosts, full boost
    write_reg(CFG_AGING_EN, 16'd1);
    write_reg(CFG_PERIOD, 16'd0);
    write_reg(CFG_THRESH, 16'd0);
    write_reg(CFG_BOOST, 16'd31);
    random_phase(90, 15, 1'b0);
    drain();

    // largest period and threshold, no boost, no inheritance depth
    write_reg(CFG_PERIOD, 16'hffff);
    write_reg(CFG_THRESH, 16'hffff);
    write_reg(CFG_BOOST, 16'd0);
    write_reg(CFG_DEPTH, 16'd0);
    random_phase(60, 30, 1'b1);
    drain();

    // stopped, inheritance off
    write_reg(CFG_RUNNING, 16'd0);
    write_reg(CFG_INH_EN, 16'd0);
    write_reg(CFG_DEPTH, 16'd8);
    random_phase(50, 30, 1'b0);
    drain();

    // restart with short aging and a shallow depth
    write_reg(CFG_RUNNING, 16'd1);
    write_reg(CFG_INH_EN, 16'd1);
    write_reg(CFG_DEPTH, 16'd3);
    write_reg(CFG_PERIOD, 16'd2);
    write_reg(CFG_THRESH, 16'd3);
    write_reg(CFG_BOOST, 16'd4);
    random_phase(90, 25, 1'b1);
    drain();
    repeat (30) @(posedge clk);

    if (pending != 0) $error("%0d expected words never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== priority_ready_queue_scheduler.f =====
+incdir+src
src/prqs_pkg.sv
src/priority_ready_queue_scheduler.sv
sim/prqs_checker.sv
sim/testbench.sv
